FILE: rtl/md5_pkg.sv
// md5_pkg: shared types, constants and round functions of the md5 digest block
package md5_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0]  MARKER   = 8'h80;
  localparam logic [3:0]  LEN_POS  = 4'd14;
  localparam logic [5:0]  WORD_BITS = 6'd32;
  localparam logic [5:0]  LAST_RND = 6'd63;

  // one classified word on its way from the front to the back
  typedef struct packed {
    logic [31:0] word;
    logic [5:0]  add_bits;
    logic        last;
    logic        extra;
  } item_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    logic [4:0] s;
    case (rnd[5:4])
      2'd0: begin
        case (rnd[1:0])
          2'd0: s = 5'd7;
          2'd1: s = 5'd12;
          2'd2: s = 5'd17;
          default: s = 5'd22;
        endcase
      end
      2'd1: begin
        case (rnd[1:0])
          2'd0: s = 5'd5;
          2'd1: s = 5'd9;
          2'd2: s = 5'd14;
          default: s = 5'd20;
        endcase
      end
      2'd2: begin
        case (rnd[1:0])
          2'd0: s = 5'd4;
          2'd1: s = 5'd11;
          2'd2: s = 5'd16;
          default: s = 5'd23;
        endcase
      end
      default: begin
        case (rnd[1:0])
          2'd0: s = 5'd6;
          2'd1: s = 5'd10;
          2'd2: s = 5'd15;
          default: s = 5'd21;
        endcase
      end
    endcase
    return s;
  endfunction

  // message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] lo;
    logic [3:0] g;
    lo = rnd[3:0];
    case (rnd[5:4])
      2'd0: g = lo;
      2'd1: g = 4'(lo * 4'd5 + 4'd1);
      2'd2: g = 4'(lo * 4'd3 + 4'd5);
      default: g = 4'(lo * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] quarter,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    case (quarter)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

FILE: rtl/md5_in_if.sv
// md5_in_if: input word channel with valid/ready handshake
interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source(output valid, data_word, valid_bytes, last_word, input ready);
  modport sink(input valid, data_word, valid_bytes, last_word, output ready);
endinterface

FILE: rtl/md5_out_if.sv
// md5_out_if: digest result channel with valid/ready handshake
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source(output valid, digest_a, digest_b, digest_c, digest_d, input ready);
  modport sink(input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

FILE: rtl/md5_front.sv
// md5_front: accepts input words, masks and marks the final word, counts its bits
module md5_front (
  md5_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_wr,
  output md5_pkg::item_t  q_item
);
  import md5_pkg::*;

  logic [2:0]  count;
  logic [31:0] mask;
  logic [31:0] mark;

  assign in_ch.ready = !q_full;
  assign q_wr        = in_ch.valid && !q_full;

  // byte counts above four read as four
  assign count = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;

  always_comb begin
    case (count[1:0])
      2'd0: mask = 32'h0000_0000;
      2'd1: mask = 32'h0000_00ff;
      2'd2: mask = 32'h0000_ffff;
      default: mask = 32'h00ff_ffff;
    endcase
    mark = 32'(MARKER) << {count[1:0], 3'b000};

    q_item.last  = in_ch.last_word;
    q_item.extra = 1'b0;
    if (!in_ch.last_word) begin
      q_item.word     = in_ch.data_word;
      q_item.add_bits = WORD_BITS;
    end else begin
      q_item.add_bits = {count, 3'b000};
      if (count[2]) begin
        // full final word: the marker needs a word of its own
        q_item.word  = in_ch.data_word;
        q_item.extra = 1'b1;
      end else begin
        q_item.word = (in_ch.data_word & mask) | mark;
      end
    end
  end

endmodule

FILE: rtl/md5_fifo.sv
// md5_fifo: short queue of classified words between the front and the back
module md5_fifo #(
  parameter int Depth = md5_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  md5_pkg::item_t  wr_item,
  output logic            full,
  input  logic            rd_en,
  output md5_pkg::item_t  rd_item,
  output logic            empty
);
  import md5_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_r [Depth];
  logic [PtrW-1:0]  wptr_r;
  logic [PtrW-1:0]  rptr_r;
  logic [CntW-1:0]  cnt_r;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rptr_r];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (rd_en) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("queue read while empty");

endmodule

FILE: rtl/md5_back.sv
// md5_back: block buffer, padding sequencer, round unit and digest register
module md5_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  md5_pkg::item_t  q_item,
  output logic            q_pop,
  md5_out_if.source       out_ch
);
  import md5_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MARK   = 8'b0000_0010,
    ST_PAD    = 8'b0000_0100,
    ST_LEN_LO = 8'b0000_1000,
    ST_LEN_HI = 8'b0001_0000,
    ST_COMP   = 8'b0010_0000,
    ST_ADD    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t       state_r, state_nxt;
  state_t       ret_r, ret_nxt;
  state_t       after_st;
  logic [3:0]   pos_r;
  logic [63:0]  bits_r, bits_nxt;
  logic [31:0]  chain_r [4];
  logic [31:0]  buf_r [16];
  logic [31:0]  wa_r, wb_r, wc_r, wd_r;
  logic [5:0]   rnd_r;
  logic [31:0]  km_r;
  logic         out_valid_r;
  logic [31:0]  dig_r [4];

  logic         push_en;
  logic [31:0]  push_word;
  logic         wrap;
  logic         out_load;
  logic         chain_add;
  logic [5:0]   kidx;
  logic [31:0]  sum;
  logic [31:0]  new_b;

  // sequencer: one buffer word per cycle unless held (compression, digest wait); compression on every 16th
  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    after_st  = ST_IDLE;
    q_pop     = 1'b0;
    bits_nxt  = bits_r;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    out_load  = 1'b0;
    chain_add = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          push_en   = 1'b1;
          push_word = q_item.word;
          bits_nxt  = bits_r + 64'(q_item.add_bits);
          if (!q_item.last) begin
            after_st = ST_IDLE;
          end else if (q_item.extra) begin
            after_st = ST_MARK;
          end else begin
            after_st = ST_PAD;
          end
        end
      end
      ST_MARK: begin
        push_en   = 1'b1;
        push_word = 32'(MARKER);
        after_st  = ST_PAD;
      end
      ST_PAD: begin
        if (pos_r == LEN_POS) begin
          state_nxt = ST_LEN_LO;
        end else begin
          push_en  = 1'b1;
          after_st = ST_PAD;
        end
      end
      ST_LEN_LO: begin
        push_en   = 1'b1;
        push_word = bits_r[31:0];
        after_st  = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        push_en   = 1'b1;
        push_word = bits_r[63:32];
        after_st  = ST_OUT;
      end
      ST_COMP: begin
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_add = 1'b1;
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          bits_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    wrap = push_en && (pos_r == 4'hf);
    if (push_en) begin
      if (wrap) begin
        state_nxt = ST_COMP;
        ret_nxt   = after_st;
      end else begin
        state_nxt = after_st;
      end
    end
  end

  // round datapath; constant plus message word for the next round is registered while the current round runs
  assign kidx  = (state_r == ST_COMP) ? rnd_r + 6'd1 : '0;
  assign sum   = round_f(rnd_r[5:4], wb_r, wc_r, wd_r) + wa_r + km_r;
  assign new_b = wb_r + rotl32(sum, rot_amt(rnd_r));

  always_ff @(posedge clk) begin
    if (push_en) begin
      buf_r[pos_r] <= push_word;
    end
    km_r <= ROUND_K[kidx] + buf_r[msg_index(kidx)];
    if (wrap) begin
      wa_r <= chain_r[0];
      wb_r <= chain_r[1];
      wc_r <= chain_r[2];
      wd_r <= chain_r[3];
    end else if (state_r == ST_COMP) begin
      wa_r <= wd_r;
      wd_r <= wc_r;
      wc_r <= wb_r;
      wb_r <= new_b;
    end
    if (out_load) begin
      dig_r <= chain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      pos_r       <= '0;
      bits_r      <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= IV_A;
      chain_r[1]  <= IV_B;
      chain_r[2]  <= IV_C;
      chain_r[3]  <= IV_D;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      bits_r  <= bits_nxt;
      if (push_en) begin
        pos_r <= pos_r + 4'd1;
      end
      if (wrap) begin
        rnd_r <= '0;
      end else if (state_r == ST_COMP) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (chain_add) begin
        chain_r[0] <= chain_r[0] + wa_r;
        chain_r[1] <= chain_r[1] + wb_r;
        chain_r[2] <= chain_r[2] + wc_r;
        chain_r[3] <= chain_r[3] + wd_r;
      end else if (out_load) begin
        chain_r[0] <= IV_A;
        chain_r[1] <= IV_B;
        chain_r[2] <= IV_C;
        chain_r[3] <= IV_D;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.digest_a = dig_r[0];
  assign out_ch.digest_b = dig_r[1];
  assign out_ch.digest_c = dig_r[2];
  assign out_ch.digest_d = dig_r[3];

  a_comp_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP || state_r == ST_ADD) |-> pos_r == 4'd0)
    else $error("compression running on a partly filled block");

  a_comp_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && rnd_r == LAST_RND) |=> state_r == ST_ADD)
    else $error("compression did not finish after the last round");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("digest presented outside the output step");

endmodule

FILE: rtl/md5_digest.sv
// md5_digest: top level of the streaming md5 message digest
// Streaming MD5 hasher. Message words enter on in_ch as little-endian 32-bit
// words (first byte in bits 7:0); valid_bytes counts only on the word that
// carries last_word, and values above four read as four. A front stage masks
// and marks the final word and drops each word into a small queue of
// QueueDepth entries, so input keeps flowing while the back end is busy until
// the queue fills. The back end writes one word per cycle, when no compression
// or digest wait holds it, into the 16-word block buffer; every sixteenth word
// starts the compression, which uses a single round unit at one round per
// cycle and then folds the result into the chaining words. The back end takes
// no words while a compression runs, so the sustained rate is set by the round
// unit. After the last word the back end pads with the marker, zero words and
// the 64-bit bit length (with a turn-around step before the length, and one or
// two compressions), then loads the digest into the out_ch register and
// returns to the initial chaining values. A waiting digest does not hold up
// the next message's words until that message's own digest is due.
module md5_digest #(
  parameter int QueueDepth = md5_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  md5_in_if.sink     in_ch,
  md5_out_if.source  out_ch
);
  import md5_pkg::*;

  // front to queue
  logic   q_wr;
  logic   q_full;
  item_t  q_wr_item;

  // queue to back
  logic   q_pop;
  logic   q_empty;
  item_t  q_rd_item;

  md5_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_item (q_wr_item)
  );

  md5_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  // back end takes one queued transfer at a time
  md5_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: sim/md5_digest_check.sv
// md5_digest_check: watches both channels, predicts every digest and compares it
module md5_digest_check (
  input  logic clk,
  input  logic rst_n,
  md5_in_if    in_ch,
  md5_out_if   out_ch,
  output int   fail_count,
  output int   digests_checked,
  output int   digests_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int          WORD_BYTES = 4;
  localparam logic [3:0]  LENGTH_SLOT = 4'd14;

  localparam int SHIFT_BY [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  logic [31:0] chain [4];
  logic [31:0] block_words [16];
  logic [3:0]  fill;
  logic [63:0] msg_bits;
  digest_t     expected_digests [$];

  function automatic void restart_message();
    chain[0] = INIT_A;
    chain[1] = INIT_B;
    chain[2] = INIT_C;
    chain[3] = INIT_D;
    fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, f;
    int g, s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      s = SHIFT_BY[(r / 16) * 4 + r % 4];
      f = f + a + SINE_K[r] + block_words[g];
      a = d;
      d = c;
      c = b;
      b = b + ((f << s) | (f >> (32 - s)));
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  function automatic void absorb_word(input logic [31:0] w);
    block_words[fill] = w;
    fill = fill + 4'd1;
    if (fill == 4'd0) compress_block();
  endfunction

  // one accepted word; a last word pads the message and yields a digest
  function automatic void take_word(input logic [31:0] data, input logic [2:0] nbytes,
                                    input logic last);
    int          used;
    logic [31:0] keep;
    digest_t     dg;
    if (!last) begin
      msg_bits = msg_bits + 64'd32;
      absorb_word(data);
      return;
    end
    used = (nbytes > 3'(WORD_BYTES)) ? WORD_BYTES : int'(nbytes);
    msg_bits = msg_bits + 64'(used * 8);
    if (used == WORD_BYTES) begin
      absorb_word(data);
      absorb_word(32'(PAD_MARK));
    end else begin
      keep = (used == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * used));
      absorb_word((data & keep) | (32'(PAD_MARK) << (8 * used)));
    end
    if (fill > LENGTH_SLOT) absorb_word(32'h0);
    while (fill < LENGTH_SLOT) absorb_word(32'h0);
    absorb_word(msg_bits[31:0]);
    absorb_word(msg_bits[63:32]);
    dg = '{a: chain[0], b: chain[1], c: chain[2], d: chain[3]};
    expected_digests.push_back(dg);
    restart_message();
  endfunction

  function automatic void check_word(input string label, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %08h, actual %08h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    digest_t want;
    if (!rst_n) begin
      restart_message();
      expected_digests.delete();
      fail_count = 0;
      digests_checked = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digests.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected digest, expected none, actual %08h %08h %08h %08h",
                   $time, out_ch.digest_a, out_ch.digest_b, out_ch.digest_c, out_ch.digest_d);
        end else begin
          want = expected_digests.pop_front();
          check_word("digest_a", want.a, out_ch.digest_a);
          check_word("digest_b", want.b, out_ch.digest_b);
          check_word("digest_c", want.c, out_ch.digest_c);
          check_word("digest_d", want.d, out_ch.digest_d);
          digests_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        take_word(in_ch.data_word, in_ch.valid_bytes, in_ch.last_word);
    end
    digests_pending = expected_digests.size();
  end

endmodule

FILE: sim/tb_md5_digest.sv
// tb_md5_digest: stimulus, handshake timing and verdict for the md5 digest block
module tb_md5_digest;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 10;
  localparam int WORD_TARGET     = 550;     // rough size of the random part
  localparam int MIN_DIGESTS     = 40;      // keep going until this many messages
  localparam int HOLD_OFF_CYCLES = 600;     // long output stall to back the block up
  localparam int DRAIN_CYCLES    = 300;     // covers two compressions plus padding
  localparam int CYCLE_LIMIT     = 500000;

  logic clk;
  logic rst_n;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  int sender_idle_pct;
  int receiver_idle_pct;
  bit hold_off_req;
  int words_sent;
  int messages_sent;
  int fail_count;
  int digests_checked;
  int digests_pending;
  int cycle_count;

  md5_digest dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicts and compares on its own; only the counts come back here
  md5_digest_check digest_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .digests_checked (digests_checked),
    .digests_pending (digests_pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d digests still outstanding",
             cycle_count, digests_pending);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off when asked
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // offer one word at a falling edge and return at the falling edge after its transfer;
  // valid is only lowered when a gap is taken, so back-to-back words keep it high
  task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic last);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_word   <= data;
    in_ch.valid_bytes <= nbytes;
    in_ch.last_word   <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    words_sent++;
    if (last) messages_sent++;
  endtask

  initial begin
    int n_body;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_word   = '0;
    in_ch.valid_bytes = '0;
    in_ch.last_word   = 1'b0;
    sender_idle_pct   = 33;
    receiver_idle_pct = 74;
    hold_off_req      = 1'b0;
    words_sent        = 0;
    messages_sent     = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: lone last words with byte counts 0, 1, 3, 4, 5 and 7
    send_word(32'hffffffff, 3'd0, 1'b1);  // empty message, junk bytes must be cleared
    send_word(32'h00000061, 3'd1, 1'b1);  // single byte
    send_word(32'hff636261, 3'd3, 1'b1);  // three bytes, top byte is junk
    send_word(32'hffffffff, 3'd4, 1'b1);  // full last word, marker spills to next word
    send_word(32'h00000000, 3'd7, 1'b1);  // oversized count reads as four
    send_word(32'h89abcdef, 3'd5, 1'b1);
    // short count on a body word is ignored
    send_word(32'hffffffff, 3'd2, 1'b0);
    send_word(32'h12345678, 3'd2, 1'b1);
    // full last word at slot 13: marker lands on 14, length forces a second block
    for (int i = 0; i < 13; i++)
      send_word((i % 2 == 1) ? 32'hffffffff : 32'h0, 3'($urandom_range(0, 7)), 1'b0);
    send_word(32'ha5a5a5a5, 3'd4, 1'b1);

    // random messages: mostly short, now and then a multi-block one
    while (words_sent < WORD_TARGET || messages_sent < MIN_DIGESTS) begin
      if (words_sent >= 2 * WORD_TARGET / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_req      = 1'b1;
      end else if (words_sent >= WORD_TARGET / 3) begin
        sender_idle_pct   = 74;
        receiver_idle_pct = 33;
      end
      n_body = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 20);
      for (int k = 0; k < n_body; k++)
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    end
    in_ch.valid <= 1'b0;

    // let every predicted digest come out, then watch for strays
    while (digests_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d words in %0d messages, byte counts 0 to 7 and both padding paths",
             words_sent, messages_sent);
    $display("compared %0d digests under three idle mixes and a %0d-cycle output hold-off",
             digests_checked, HOLD_OFF_CYCLES);
    if (fail_count == 0 && digests_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: md5_digest.f
rtl/md5_pkg.sv
rtl/md5_in_if.sv
rtl/md5_out_if.sv
rtl/md5_front.sv
rtl/md5_fifo.sv
rtl/md5_back.sv
rtl/md5_digest.sv
sim/md5_digest_check.sv
sim/tb_md5_digest.sv
